### rtl/core/a2c_pkg.sv
// Shared types and constants for the cubic octant atan2 pipeline.
// Has no dependencies; every other file in rtl/core refers to it by scoped names.
package a2c_pkg;

	// Result width and the Q1.15 ratio format.
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned R_FRAC  = 15;
	localparam int unsigned QUO_W   = R_FRAC + 1;

	// Largest positive ratio code; a negative ratio may reach exactly -1.
	localparam logic [QUO_W-1:0] R_MAX = 16'h7FFF;

	// Polynomial coefficients in Q0.16: round(0.1963 * 2^16) and round(0.9817 * 2^16).
	localparam logic [13:0] COEF_A = 14'd12865;
	localparam logic [15:0] COEF_B = 16'd64337;

	// Pi in Q2.62, source of both octant base angles.
	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

	// Sign information that travels alongside each transaction.
	typedef struct packed {
		logic xneg;
		logic yneg;
		logic mneg;
	} side_t;

endpackage

### rtl/core/atan2_cubic_octant_approx.sv
// Top level of the cubic octant atan2 approximation: front end, divider, polynomial, output skid.
// Instantiates a2c_prep, a2c_div and a2c_poly; uses a2c_pkg.
//
//   channel   signals                                  direction
//   input     in_valid, in_ready, y_in, x_in           sink
//   output    out_valid, out_ready, angle_out          source
//
// One transaction enters per clock while in_ready is high. A transaction passes through the
// front end, the divider, the polynomial and the output register in that order; the divider
// resolves one quotient bit per stage over 16 stages, and there are also 3 front-end,
// 7 polynomial and 1 output stage.
// Reset clears only the valid bits and the output handshake state.
// A result arriving during an output stall fills the skid register and then freezes the whole pipeline;
// in_ready comes straight from a flop.
module atan2_cubic_octant_approx #(
	parameter int unsigned SAMPLE_WIDTH    = 16,
	parameter int unsigned ANGLE_FRAC_BITS = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]      y_in,
	input  logic signed [SAMPLE_WIDTH-1:0]      x_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [a2c_pkg::ANGLE_W-1:0]  angle_out
);

	localparam int unsigned NW = SAMPLE_WIDTH + a2c_pkg::QUO_W;

	logic                              en;
	logic                              pre_valid;
	logic [NW-1:0]                     pre_num;
	logic [SAMPLE_WIDTH:0]             pre_den;
	a2c_pkg::side_t                    pre_side;
	logic                              div_valid;
	logic [a2c_pkg::QUO_W-1:0]         div_quo;
	a2c_pkg::side_t                    div_side;
	logic                              fin_valid;
	logic [a2c_pkg::ANGLE_W-1:0]       fin_angle;

	logic                              out_valid_q;
	logic [a2c_pkg::ANGLE_W-1:0]       angle_q;
	logic                              skid_full_q;
	logic [a2c_pkg::ANGLE_W-1:0]       skid_q;
	logic                              take;

	assign en       = ~skid_full_q;
	assign in_ready = ~skid_full_q;

	a2c_prep #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (in_valid),
		.y        (y_in),
		.x        (x_in),
		.dn_valid (pre_valid),
		.num      (pre_num),
		.den      (pre_den),
		.side     (pre_side)
	);

	a2c_div #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (pre_valid),
		.num      (pre_num),
		.den      (pre_den),
		.side     (pre_side),
		.dn_valid (div_valid),
		.quo      (div_quo),
		.side_o   (div_side)
	);

	a2c_poly #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (div_valid),
		.quo      (div_quo),
		.side     (div_side),
		.dn_valid (fin_valid),
		.angle    (fin_angle)
	);

	// The output register is empty or is being read; otherwise a result arriving from the
	// pipeline is parked in the skid register.
	assign take = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (take) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= fin_valid;
			end
		end else if (fin_valid && !skid_full_q) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			angle_q <= skid_full_q ? skid_q : fin_angle;
		end else if (fin_valid && !skid_full_q) begin
			skid_q <= fin_angle;
		end
	end

	assign out_valid = out_valid_q;
	assign angle_out = angle_q;

`ifndef SYNTHESIS
	a_skid_needs_out : assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_skid_from_stall : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid register filled without an output stall");

	a_skid_drains : assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && out_ready) |=> (!skid_full_q && out_valid_q))
		else $error("skid register failed to drain into the output register");
`endif

endmodule

### rtl/core/a2c_prep.sv
// Front end of the atan2 pipeline: magnitudes, ratio numerator and denominator.
// Three register stages; uses a2c_pkg::side_t.
module a2c_prep #(
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               up_valid,
	input  logic [SAMPLE_WIDTH-1:0]            y,
	input  logic [SAMPLE_WIDTH-1:0]            x,
	output logic                               dn_valid,
	output logic [SAMPLE_WIDTH+a2c_pkg::QUO_W-1:0] num,
	output logic [SAMPLE_WIDTH:0]              den,
	output a2c_pkg::side_t                     side
);

	localparam int unsigned W  = SAMPLE_WIDTH;
	localparam int unsigned NW = W + a2c_pkg::QUO_W;

	logic                   valid_s1, valid_s2, valid_s3;
	logic [W-1:0]           ay_s1, ax_s1;
	a2c_pkg::side_t         side_s1, side_s2, side_s3;
	logic [W-1:0]           mag_s2;
	logic [W:0]             den_s2, den_s3;
	logic [NW-1:0]          num_s3;

	logic [W-1:0]           ay_c, ax_c;
	logic [W:0]             dxa_c, dax_c, den_c;
	logic [W-1:0]           mag_c;
	logic                   mneg_c;
	logic [NW-1:0]          num_c;

	// The extra LSB on |y| keeps the denominator away from zero.
	always_comb begin
		ay_c = y[W-1] ? (~y + W'(2)) : (y + W'(1));
		ax_c = x[W-1] ? (~x + W'(1)) : x;
	end

	// For x >= 0 the numerator is |x| - ay, otherwise ay - |x|; the denominator is always
	// |x| + ay, so only the magnitude and the sign of the numerator are carried on.
	always_comb begin
		dxa_c  = {1'b0, ax_s1} - {1'b0, ay_s1};
		dax_c  = {1'b0, ay_s1} - {1'b0, ax_s1};
		den_c  = {1'b0, ax_s1} + {1'b0, ay_s1};
		mag_c  = dxa_c[W] ? dax_c[W-1:0] : dxa_c[W-1:0];
		mneg_c = side_s1.xneg ? dax_c[W] : dxa_c[W];
	end

	// Dividend for a Q1.15 quotient rounded to nearest.
	always_comb begin
		num_c = {1'b0, mag_s2, {a2c_pkg::R_FRAC{1'b0}}} + NW'(den_s2[W:1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ay_s1        <= ay_c;
			ax_s1        <= ax_c;
			side_s1.xneg <= x[W-1];
			side_s1.yneg <= y[W-1];
			side_s1.mneg <= 1'b0;

			mag_s2       <= mag_c;
			den_s2       <= den_c;
			side_s2.xneg <= side_s1.xneg;
			side_s2.yneg <= side_s1.yneg;
			side_s2.mneg <= mneg_c;

			num_s3       <= num_c;
			den_s3       <= den_s2;
			side_s3      <= side_s2;
		end
	end

	assign dn_valid = valid_s3;
	assign num      = num_s3;
	assign den      = den_s3;
	assign side     = side_s3;

endmodule

### rtl/core/a2c_div.sv
// Pipelined restoring divider producing the 16-bit ratio magnitude, one quotient bit a stage.
// Uses a2c_pkg for the quotient width and the sideband type.
module a2c_div #(
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   up_valid,
	input  logic [SAMPLE_WIDTH+a2c_pkg::QUO_W-1:0] num,
	input  logic [SAMPLE_WIDTH:0]                  den,
	input  a2c_pkg::side_t                         side,
	output logic                                   dn_valid,
	output logic [a2c_pkg::QUO_W-1:0]              quo,
	output a2c_pkg::side_t                         side_o
);

	localparam int unsigned W  = SAMPLE_WIDTH;
	localparam int unsigned NW = W + a2c_pkg::QUO_W;
	localparam int unsigned QB = a2c_pkg::QUO_W;

	logic                   vld_s  [QB];
	logic [W:0]             rem_s  [QB];
	logic [W:0]             den_s  [QB];
	logic [QB-1:0]          low_s  [QB];
	logic [QB-1:0]          quo_s  [QB];
	a2c_pkg::side_t         side_s [QB];

	logic                   vsrc   [QB];
	logic [W:0]             rsrc   [QB];
	logic [W:0]             dsrc   [QB];
	logic [QB-1:0]          lsrc   [QB];
	logic [QB-1:0]          qsrc   [QB];
	a2c_pkg::side_t         ssrc   [QB];
	logic [W+1:0]           trial  [QB];
	logic [W+1:0]           diff   [QB];
	logic [W:0]             rem_nx [QB];
	logic                   qbit   [QB];

	// The partial remainder always stays below the divisor, so a single trial
	// subtraction decides each quotient bit.
	always_comb begin
		for (int i = 0; i < QB; i++) begin
			if (i == 0) begin
				vsrc[i] = up_valid;
				rsrc[i] = {1'b0, num[NW-1:QB]};
				dsrc[i] = den;
				lsrc[i] = num[QB-1:0];
				qsrc[i] = '0;
				ssrc[i] = side;
			end else begin
				vsrc[i] = vld_s[i-1];
				rsrc[i] = rem_s[i-1];
				dsrc[i] = den_s[i-1];
				lsrc[i] = low_s[i-1];
				qsrc[i] = quo_s[i-1];
				ssrc[i] = side_s[i-1];
			end
			trial[i]  = {rsrc[i], lsrc[i][QB-1]};
			diff[i]   = trial[i] - {1'b0, dsrc[i]};
			qbit[i]   = ~diff[i][W+1];
			rem_nx[i] = qbit[i] ? diff[i][W:0] : trial[i][W:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QB; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			for (int i = 0; i < QB; i++) begin
				vld_s[i] <= vsrc[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QB; i++) begin
				rem_s[i]  <= rem_nx[i];
				den_s[i]  <= dsrc[i];
				low_s[i]  <= {lsrc[i][QB-2:0], 1'b0};
				quo_s[i]  <= {qsrc[i][QB-2:0], qbit[i]};
				side_s[i] <= ssrc[i];
			end
		end
	end

	assign dn_valid = vld_s[QB-1];
	assign quo      = quo_s[QB-1];
	assign side_o   = side_s[QB-1];

endmodule

### rtl/core/a2c_poly.sv
// Back end of the atan2 pipeline: signed ratio, cubic correction, octant base and saturation.
// Seven register stages; uses a2c_pkg coefficients, pi and the sideband type.
module a2c_poly #(
	parameter int unsigned ANGLE_FRAC_BITS = 13
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               up_valid,
	input  logic [a2c_pkg::QUO_W-1:0]          quo,
	input  a2c_pkg::side_t                     side,
	output logic                               dn_valid,
	output logic [a2c_pkg::ANGLE_W-1:0]        angle
);

	localparam int unsigned F    = ANGLE_FRAC_BITS;
	localparam int unsigned SH   = 61 - F;
	localparam int unsigned BSH  = 62 - F;
	localparam int unsigned SUMW = (F + 3 > a2c_pkg::ANGLE_W + 1) ? F + 3 : a2c_pkg::ANGLE_W + 1;

	localparam logic [63:0] QPI   = a2c_pkg::PI_Q62 >> 2;
	localparam logic [63:0] QPI3  = QPI * 64'd3;
	localparam logic [63:0] BASE1 = (QPI + (64'd1 << (BSH - 1))) >> BSH;
	localparam logic [63:0] BASE3 = (QPI3 + (64'd1 << (BSH - 1))) >> BSH;
	localparam logic signed [SUMW-1:0] B1_POS = SUMW'(BASE1);
	localparam logic signed [SUMW-1:0] B3_POS = SUMW'(BASE3);
	localparam logic signed [SUMW-1:0] B1_NEG = -B1_POS;
	localparam logic signed [SUMW-1:0] B3_NEG = -B3_POS;
	localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((2 ** (a2c_pkg::ANGLE_W - 1)) - 1);
	localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(-(2 ** (a2c_pkg::ANGLE_W - 1)));
	localparam logic [61:0]            HALF   = 62'd1 << (SH - 1);

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	a2c_pkg::side_t         side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic signed [15:0]     r_s1, r_s2, r_s3;
	logic [30:0]            r2_s2;
	logic signed [46:0]     s_s3;
	logic signed [62:0]     p_s4;
	logic [61:0]            pmag_s5;
	logic                   pn_s5;
	logic [F:0]             cm_s6;
	logic                   cneg_s6;
	logic [a2c_pkg::ANGLE_W-1:0] angle_s7;

	logic [16:0]            rneg_c;
	logic [15:0]            r_c;
	logic signed [31:0]     r2_c;
	logic [44:0]            ar2_c;
	logic signed [46:0]     s_c;
	logic signed [62:0]     p_c;
	logic signed [62:0]     pneg_c;
	logic [61:0]            pmag_c;
	logic [61:0]            rnd_c;
	logic signed [SUMW-1:0] base_c;
	logic signed [SUMW-1:0] cmx_c;
	logic signed [SUMW-1:0] sum_c;
	logic [a2c_pkg::ANGLE_W-1:0] angle_c;

	// A positive ratio of exactly one is clamped; minus one is representable.
	always_comb begin
		rneg_c = 17'd0 - {1'b0, quo};
		if (side.mneg) begin
			r_c = rneg_c[15:0];
		end else if (quo[a2c_pkg::QUO_W-1]) begin
			r_c = a2c_pkg::R_MAX;
		end else begin
			r_c = quo;
		end
	end

	always_comb begin
		r2_c  = 32'(r_s1) * 32'(r_s1);
		ar2_c = 45'(a2c_pkg::COEF_A) * 45'(r2_s2);
		s_c   = $signed({2'b00, ar2_c}) - $signed({1'b0, a2c_pkg::COEF_B, 30'd0});
		p_c   = 63'(s_s3) * 63'(r_s3);
	end

	always_comb begin
		pneg_c = -p_s4;
		pmag_c = p_s4[62] ? pneg_c[61:0] : p_s4[61:0];
		rnd_c  = pmag_s5 + HALF;
	end

	// Negation for y < 0 is folded into both the base and the sign of the correction.
	always_comb begin
		if (side_s6.xneg) begin
			base_c = side_s6.yneg ? B3_NEG : B3_POS;
		end else begin
			base_c = side_s6.yneg ? B1_NEG : B1_POS;
		end
		cmx_c = SUMW'(cm_s6);
		sum_c = cneg_s6 ? (base_c - cmx_c) : (base_c + cmx_c);
		if (sum_c > SAT_HI) begin
			angle_c = SAT_HI[a2c_pkg::ANGLE_W-1:0];
		end else if (sum_c < SAT_LO) begin
			angle_c = SAT_LO[a2c_pkg::ANGLE_W-1:0];
		end else begin
			angle_c = sum_c[a2c_pkg::ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= up_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1     <= r_c;
			side_s1  <= side;

			r_s2     <= r_s1;
			r2_s2    <= r2_c[30:0];
			side_s2  <= side_s1;

			r_s3     <= r_s2;
			s_s3     <= s_c;
			side_s3  <= side_s2;

			p_s4     <= p_c;
			side_s4  <= side_s3;

			pmag_s5  <= pmag_c;
			pn_s5    <= p_s4[62];
			side_s5  <= side_s4;

			cm_s6    <= rnd_c[61:SH];
			cneg_s6  <= pn_s5 ^ side_s5.yneg;
			side_s6  <= side_s5;

			angle_s7 <= angle_c;
		end
	end

	assign dn_valid = vld_s7;
	assign angle    = angle_s7;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for atan2_cubic_octant_approx: directed and random (y, x) pairs
// with random idling on both handshakes, checked against a bit-accurate angle predictor.
// Depends on a2c_pkg and the atan2_cubic_octant_approx top level only.
`timescale 1ns / 100ps

module tb;

	localparam int unsigned W = 16;
	localparam int unsigned RAND_PAIRS = 1350;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 40;
	// Window of the random phase in which neither side idles.
	localparam int unsigned CALM_FIRST = 500;
	localparam int unsigned CALM_LAST = 800;

	// Fixed-point constants of the approximation.
	localparam longint unsigned QUARTER_PI_Q62 = 64'hC90FDAA22168C235 >> 2;
	localparam longint COEF_A_Q16 = 12865;
	localparam longint COEF_B_Q16 = 64337;
	localparam int unsigned R_FRAC = 15;
	localparam int unsigned ANGLE_FRAC = 13;
	localparam longint SMAX = 32767;
	localparam longint SMIN = -32768;

	typedef struct {
		logic signed [W-1:0] y;
		logic signed [W-1:0] x;
		logic signed [a2c_pkg::ANGLE_W-1:0] angle;
	} angle_entry_t;

	class angle_scoreboard;
		angle_entry_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function logic signed [a2c_pkg::ANGLE_W-1:0] predict_angle(logic signed [W-1:0] y,
				logic signed [W-1:0] x);
			longint sy, sx, ay, num, den, r, r2, s, p, corr, angle;
			longint unsigned mag, cm, base_q;
			sy = longint'(y);
			sx = longint'(x);
			ay = (sy < 0 ? -sy : sy) + 1;
			if (sx < 0) begin
				num = sx + ay;
				den = ay - sx;
				base_q = QUARTER_PI_Q62 * 3;
			end else begin
				num = sx - ay;
				den = sx + ay;
				base_q = QUARTER_PI_Q62;
			end
			base_q = (base_q + (64'd1 << (62 - ANGLE_FRAC - 1))) >> (62 - ANGLE_FRAC);
			// Ratio in Q1.15, rounded half away from zero; only -1 is allowed to reach full scale.
			mag = num < 0 ? -num : num;
			mag = ((mag << R_FRAC) + (den >> 1)) / den;
			if (num < 0) begin
				if (mag > 32768)
					mag = 32768;
				r = -longint'(mag);
			end else begin
				if (mag > 32767)
					mag = 32767;
				r = longint'(mag);
			end
			r2 = r * r;
			s = COEF_A_Q16 * r2 - (COEF_B_Q16 << 30);
			p = s * r;
			cm = p < 0 ? -p : p;
			cm = (cm + (64'd1 << (61 - ANGLE_FRAC - 1))) >> (61 - ANGLE_FRAC);
			corr = p < 0 ? -longint'(cm) : longint'(cm);
			angle = longint'(base_q) + corr;
			if (sy < 0)
				angle = -angle;
			if (angle > SMAX)
				angle = SMAX;
			if (angle < SMIN)
				angle = SMIN;
			return angle[a2c_pkg::ANGLE_W-1:0];
		endfunction

		function void note_pair(logic signed [W-1:0] y, logic signed [W-1:0] x);
			angle_entry_t e;
			e.y = y;
			e.x = x;
			e.angle = predict_angle(y, x);
			pending.push_back(e);
		endfunction

		function void check_angle(logic signed [a2c_pkg::ANGLE_W-1:0] actual);
			angle_entry_t e;
			if (pending.size() == 0) begin
				$error("angle_out: no transaction outstanding, actual %0d", actual);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (actual !== e.angle) begin
				$error("angle_out (y=%0d x=%0d): expected %0d, actual %0d",
					e.y, e.x, e.angle, actual);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [W-1:0] y_in = '0;
	logic signed [W-1:0] x_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [a2c_pkg::ANGLE_W-1:0] angle_out;

	angle_scoreboard sb = new();
	bit calm = 1'b0;
	int unsigned cycles = 0;

	atan2_cubic_octant_approx uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.y_in      (y_in),
		.x_in      (x_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.angle_out (angle_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: check every accepted transaction, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_angle(angle_out);
		out_ready <= calm || ($urandom_range(99) >= 16);
	end

	function automatic logic signed [W-1:0] clamp16(int v);
		if (v > SMAX)
			return W'(SMAX);
		if (v < SMIN)
			return W'(SMIN);
		return W'(v);
	endfunction

	task automatic drive_pair(logic signed [W-1:0] y, logic signed [W-1:0] x);
		if (!calm) begin
			while ($urandom_range(99) < 16) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		y_in <= y;
		x_in <= x;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_pair(y, x);
	endtask

	task automatic drive_random_pair();
		int sel, a, b, off;
		sel = $urandom_range(3);
		a = int'($urandom_range(65535)) - 32768;
		b = int'($urandom_range(65535)) - 32768;
		off = int'($urandom_range(8)) - 4;
		case (sel)
			0: drive_pair(W'(a), W'(b));
			1: drive_pair(W'(int'($urandom_range(127)) - 64), W'(int'($urandom_range(127)) - 64));
			// Near the diagonals, where the ratio is close to zero and rounding matters most.
			2: drive_pair(clamp16(($urandom_range(1) ? a : -a) + off), clamp16(a));
			default: begin
				case ($urandom_range(4))
					0: a = int'(SMIN);
					1: a = -1;
					2: a = 0;
					3: a = 1;
					default: a = int'(SMAX);
				endcase
				if ($urandom_range(1))
					drive_pair(W'(a), W'(b));
				else
					drive_pair(W'(b), W'(a));
			end
		endcase
	endtask

	initial begin
		int dir_y[] = '{0, 0, -1, 1, 0, 0, -32768, 32767, -32768, 32767, -32768, 32767,
			0, 0, -1, 1, -1, 1, 1000, -1000, 999, -1000, 32767, -32768};
		int dir_x[] = '{0, -1, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768, 0, 0,
			1, -32768, -1, -1, 1, 1, 1001, 1001, -1000, -999, 32766, -32767};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_y[i])
			drive_pair(W'(dir_y[i]), W'(dir_x[i]));
		for (int unsigned n = 0; n < RAND_PAIRS; n++) begin
			calm = (n >= CALM_FIRST) && (n < CALM_LAST);
			drive_random_pair();
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
rtl/core/a2c_pkg.sv
rtl/core/a2c_prep.sv
rtl/core/a2c_div.sv
rtl/core/a2c_poly.sv
rtl/core/atan2_cubic_octant_approx.sv
tb/sv/tb.sv
